// ----- hw/rtl/gcms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcms_pkg: shared types and constants for the gap-constrained max-sum scorer
// Holds the fixed field widths, the sequencer states and the request format
// of the shared compare/add unit.
// ----------------------------------------------------------------------------
package gcms_pkg;

    localparam int SCORE_W  = 40;
    localparam int AMOUNT_W = 16;
    localparam int GAP_W    = 7;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // Register indexes, taken from paddr[2].
    localparam logic REG_MIN_GAP = 1'b0;
    localparam logic REG_MAX_GAP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_ADD,
        ST_UPDATE
    } state_t;

    typedef enum logic {
        OP_MAX,
        OP_ADD
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [SCORE_W-1:0] a;
        logic [SCORE_W-1:0] b;
    } alu_req_t;

endpackage

// ----- hw/rtl/gcms_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcms_alu: shared compare and saturating add unit
// Returns the larger operand or the sum held at the top of the score range.
// ----------------------------------------------------------------------------
module gcms_alu
    import gcms_pkg::*;
(
    input  alu_req_t           req,
    output logic [SCORE_W-1:0] res
);

    logic [SCORE_W:0] sum;

    // One wide adder and one wide comparator, selected by the operation.
    always_comb begin
        sum = {1'b0, req.a} + {1'b0, req.b};
        case (req.op)
            OP_MAX:  res = (req.a > req.b) ? req.a : req.b;
            OP_ADD:  res = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
            default: res = req.a;
        endcase
    end

endmodule

// ----- hw/rtl/gcms_hist_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcms_hist_mem: score history memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gcms_hist_mem
    import gcms_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [SCORE_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [SCORE_W-1:0] rdata
);

    logic [SCORE_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/gap_constrained_max_sum_dp.sv -----
`timescale 1ns / 1ps
// Steps: a request is accepted in idle, then runs setup, a scan over each predecessor
// distance in range (up to WINDOW, possibly none), add and update; a last request then
// holds its update step until the output register is free, and its result shows next cycle.
// No new request is taken until the last one ends; the scan is paced by one history
// read port and one shared compare unit scanning a stored score a cycle.
// Reset (synchronous, aresetn low): min_gap = 1, max_gap = 2, sequence cleared.
// ----------------------------------------------------------------------------
// gap_constrained_max_sum_dp: gap-constrained maximum-sum scorer
// Each amount scores itself plus the best earlier score whose distance back
// lies in [min_gap, max_gap]; the last request of a sequence returns the best
// score and clears the sequence.
// ----------------------------------------------------------------------------
module gap_constrained_max_sum_dp
    import gcms_pkg::*;
#(
    parameter int WINDOW = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    // Input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [AMOUNT_W-1:0] s_amount,
    input  logic                s_last_item,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SCORE_W-1:0]  m_best_total
);

    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int DW    = (CNT_W > GAP_W) ? CNT_W : GAP_W;

    state_t state_reg, state_next;

    logic [GAP_W-1:0]    min_gap_reg, max_gap_reg;
    logic [AMOUNT_W-1:0] amount_reg, amount_next;
    logic                last_reg, last_next;
    logic [CNT_W-1:0]    items_reg, items_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [SCORE_W-1:0]  best_reg, best_next;
    logic [SCORE_W-1:0]  acc_reg, acc_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                m_valid_reg, m_valid_next;
    logic [SCORE_W-1:0]  out_reg, out_next;

    logic [DW:0]        lo_ext, hi_ext, ptr_ext, span, start_addr;
    logic               rd_en, mem_we;
    alu_req_t           alu_req;
    logic [SCORE_W-1:0] alu_res, rdata;
    logic               cfg_wr;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_gap_reg <= GAP_W'(1);
            max_gap_reg <= GAP_W'(2);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MIN_GAP: min_gap_reg <= pwdata[GAP_W-1:0];
                REG_MAX_GAP: max_gap_reg <= pwdata[GAP_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_GAP: prdata = APB_DW'(min_gap_reg);
            REG_MAX_GAP: prdata = APB_DW'(max_gap_reg);
            default:     prdata = '0;
        endcase
    end

    // Scan range: distances lo..hi, limited by the items seen so far.
    always_comb begin
        lo_ext  = (min_gap_reg == '0) ? (DW+1)'(1) : (DW+1)'(min_gap_reg);
        hi_ext  = ((DW+1)'(max_gap_reg) < (DW+1)'(items_reg)) ?
                  (DW+1)'(max_gap_reg) : (DW+1)'(items_reg);
        ptr_ext = (DW+1)'(ptr_reg);
        span    = hi_ext - lo_ext + (DW+1)'(1);
        start_addr = (ptr_ext >= lo_ext) ? (ptr_ext - lo_ext)
                                         : (ptr_ext + (DW+1)'(WINDOW) - lo_ext);
    end

    // Shared compare/add unit operand selection.
    always_comb begin
        alu_req = '{op: OP_MAX, a: acc_reg, b: rdata};
        unique case (state_reg)
            ST_ADD:    alu_req = '{op: OP_ADD, a: acc_reg, b: SCORE_W'(amount_reg)};
            ST_UPDATE: alu_req = '{op: OP_MAX, a: best_reg, b: acc_reg};
            default:   ;
        endcase
    end

    gcms_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    gcms_hist_mem #(
        .DEPTH (WINDOW),
        .AW    (AW)
    ) u_hist (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (ptr_reg),
        .wdata (acc_reg),
        .re    (rd_en),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            items_reg   <= '0;
            ptr_reg     <= '0;
            best_reg    <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            items_reg   <= items_next;
            ptr_reg     <= ptr_next;
            best_reg    <= best_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        amount_reg <= amount_next;
        last_reg   <= last_next;
        acc_reg    <= acc_next;
        addr_reg   <= addr_next;
        remain_reg <= remain_next;
        out_reg    <= out_next;
    end

    // Sequencer next state and outputs.
    always_comb begin
        state_next   = state_reg;
        amount_next  = amount_reg;
        last_next    = last_reg;
        items_next   = items_reg;
        ptr_next     = ptr_reg;
        best_next    = best_reg;
        acc_next     = acc_reg;
        addr_next    = addr_reg;
        remain_next  = remain_reg;
        rd_pend_next = 1'b0;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        rd_en        = 1'b0;
        mem_we       = 1'b0;
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    amount_next = s_amount;
                    last_next   = s_last_item;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                acc_next    = '0;
                addr_next   = start_addr[AW-1:0];
                remain_next = (lo_ext > hi_ext) ? '0 : span[CNT_W-1:0];
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                // Issue one history read a cycle; fold in its registered data in the next cycle.
                rd_en        = (remain_reg != '0);
                rd_pend_next = rd_en;
                if (rd_en) begin
                    remain_next = remain_reg - CNT_W'(1);
                    addr_next   = (addr_reg == '0) ? AW'(WINDOW - 1)
                                                   : addr_reg - AW'(1);
                end
                if (rd_pend_reg) begin
                    acc_next = alu_res;
                end
                if (!rd_en && !rd_pend_reg) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                acc_next   = alu_res;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (last_reg) begin
                    // Hold until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        out_next     = alu_res;
                        m_valid_next = 1'b1;
                        best_next    = '0;
                        items_next   = '0;
                        ptr_next     = '0;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    mem_we     = 1'b1;
                    best_next  = alu_res;
                    ptr_next   = (ptr_reg == AW'(WINDOW - 1)) ? '0 : ptr_reg + AW'(1);
                    if (items_reg < CNT_W'(WINDOW)) begin
                        items_next = items_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_best_total = out_reg;

`ifndef SYNTH
    // A request blocks the input until its work is done.
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready again right after a request");

    // The item count saturates at the window depth.
    a_items_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        items_reg <= CNT_W'(WINDOW))
        else $error("item count beyond window");

    // A scan never covers more entries than the window holds.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (remain_reg <= CNT_W'(WINDOW)))
        else $error("scan length beyond window");

    // A result appears only after the update of a last request.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_UPDATE && last_reg))
        else $error("result without a last request");

    // Each history write happens at the end of a request.
    a_write_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (state_reg == ST_IDLE))
        else $error("history written outside the update step");
`endif

endmodule
